// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define GNMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define GNMC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs while reset is high
`define GNMC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gnmc_pkg.sv
// shared types and constants of the grid mark counter
package gnmc_pkg;

  localparam int MAX_COLS_DEF = 32;
  localparam int MAX_ROWS_DEF = 4096;

  localparam int ROWS_W     = 13;
  localparam int COLS_W     = 6;
  localparam int CNT_W      = 4;
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 5;
  localparam int IN_TDATA_W = 8;
  localparam int TDATA_W    = 24;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int OQ_DEPTH   = 4;

  localparam logic [ROWS_W-1:0] GRID_ROWS_RST = 13'd6;
  localparam logic [COLS_W-1:0] GRID_COLS_RST = 6'd6;

  // register indexes, taken from paddr[2]
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } seq_state_t;

  // marks of one column: older row in bit 1, newer row in bit 0
  typedef logic [1:0] line_pair_t;

  typedef struct packed {
    logic                 frame_end;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic [CNT_W-1:0]     neighbour_count;
  } result_t;

  typedef struct packed {
    logic                 emit_a;
    logic                 emit_b;
    logic                 frame_last;
    logic                 first_col;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } cell_meta_t;

  typedef struct packed {
    logic    wr_a;
    logic    wr_b;
    result_t res_a;
    result_t res_b;
  } pair_wr_t;

endpackage

// File: rtl/gnmc_cell.sv
// one column slot of the line delay chain
module gnmc_cell import gnmc_pkg::*; (
  input  logic       clk,
  input  logic       shift,
  input  logic       entry,
  input  line_pair_t push_bits,
  input  line_pair_t next_bits,
  output line_pair_t bits
);

  always_ff @(posedge clk) begin
    if (shift) begin
      bits <= entry ? push_bits : next_bits;
    end
  end

endmodule

// File: rtl/gnmc_window.sv
// 3x3 window registers and the two window counts
module gnmc_window import gnmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [2:0] col_vec,
  input  cell_meta_t meta_in,
  input  logic       room,
  output logic       ready,
  output pair_wr_t   wr
);

  logic       valid;
  cell_meta_t meta;
  logic [2:0] wa;
  logic [2:0] wb;
  logic [2:0] wc;
  logic       drain;
  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;

  assign drain = valid && room;
  assign ready = !valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta <= meta_in;
      wc   <= col_vec;
      if (meta_in.first_col) begin
        wa <= '0;
        wb <= '0;
      end else begin
        wa <= wb;
        wb <= wc;
      end
    end
  end

  assign cnt_a = CNT_W'($countones({wa, wb, wc}));
  assign cnt_b = CNT_W'($countones({wb, wc}));

  always_comb begin
    wr.wr_a                  = drain && meta.emit_a;
    wr.wr_b                  = drain && meta.emit_b;
    wr.res_a.frame_end       = 1'b0;
    wr.res_a.out_col         = meta.col - OUT_COL_W'(1);
    wr.res_a.out_row         = meta.row;
    wr.res_a.neighbour_count = cnt_a;
    wr.res_b.frame_end       = meta.frame_last;
    wr.res_b.out_col         = meta.col;
    wr.res_b.out_row         = meta.row;
    wr.res_b.neighbour_count = cnt_b;
  end

endmodule

// File: rtl/gnmc_outq.sv
// small result queue, up to two writes and one read per cycle
module gnmc_outq import gnmc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pair_wr_t wr,
  input  logic     pop,
  output logic     valid,
  output logic     room,
  output result_t  head
);

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  result_t         q [OQ_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic [PW-1:0]   wptr_b;

  assign wptr_b = wr.wr_a ? wptr + PW'(1) : wptr;

  always_ff @(posedge clk) begin
    if (wr.wr_a) begin
      q[wptr] <= wr.res_a;
    end
    if (wr.wr_b) begin
      q[wptr_b] <= wr.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(wr.wr_a) + PW'(wr.wr_b);
      rptr  <= rptr + PW'(pop);
      count <= count + CW'(wr.wr_a) + CW'(wr.wr_b) - CW'(pop);
    end
  end

  assign valid = count != '0;
  assign room  = count <= CW'(OQ_DEPTH - 2);
  assign head  = q[rptr];

endmodule

// File: rtl/grid_neighbour_mark_counter.sv
// top level: 3x3 marked-cell counter over a raster grid
// a window count is registered in the window, then queued, before it leaves on m_tdata
// one word in and one out per cycle while the queue has room and m_tready is high
// after a frame's last word a flush pass feeds a blank row with s_tready low
// reset clears position, flush state and result queue and sets the grid to 6 by 6
// line chain contents are not cleared; the first rows of a frame mask them out
module grid_neighbour_mark_counter import gnmc_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // [0] mark, [7:1] zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // [3:0] neighbour_count, [15:4] out_row,
                                           // [20:16] out_col, [23:21] zero
  output logic                  m_tlast,   // frame_end
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int ColW = $clog2(MAX_COLS);
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ROWS_W-1:0] grid_rows;
  logic [COLS_W-1:0] grid_cols;
  logic [RowW-1:0]   last_row;
  logic [ColW-1:0]   last_col;
  logic              cfg_wr;
  logic              reg_idx;

  seq_state_t        state;
  seq_state_t        state_next;
  logic [RowW-1:0]   row;
  logic [RowW-1:0]   row_next;
  logic [ColW-1:0]   col;
  logic [ColW-1:0]   col_next;

  logic              win_ready;
  logic              step;
  logic              mark_in;
  logic              flushing;
  logic [RowW-1:0]   center_row;
  logic              has_prev;
  line_pair_t        head;
  line_pair_t        push;
  logic [2:0]        col_vec;
  cell_meta_t        meta;
  pair_wr_t          wr;
  logic              q_room;
  result_t           q_head;

  line_pair_t        chain [MAX_COLS];

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_ROWS_RST;
      grid_cols <= GRID_COLS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GRID_ROWS: grid_rows <= pwdata[ROWS_W-1:0];
        REG_GRID_COLS: grid_cols <= pwdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_ROWS: prdata = APB_DW'(grid_rows);
      REG_GRID_COLS: prdata = APB_DW'(grid_cols);
      default:       prdata = '0;
    endcase
  end

  // effective grid bounds
  always_comb begin
    if (grid_rows == '0) begin
      last_row = '0;
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      last_row = RowW'(MAX_ROWS - 1);
    end else begin
      last_row = RowW'(grid_rows - ROWS_W'(1));
    end
    if (grid_cols == '0) begin
      last_col = '0;
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      last_col = ColW'(MAX_COLS - 1);
    end else begin
      last_col = ColW'(grid_cols - COLS_W'(1));
    end
  end

  // raster sequencer; the flush pass feeds a blank row after the last one
  assign flushing = state == ST_FLUSH;
  assign s_tready = !flushing && win_ready;
  assign step     = flushing ? win_ready : (s_tvalid && win_ready);
  assign mark_in  = flushing ? 1'b0 : s_tdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    if (cfg_wr) begin
      state_next = ST_RUN;
      row_next   = '0;
      col_next   = '0;
    end else if (step) begin
      if (col == last_col) begin
        col_next = '0;
        case (state)
          ST_RUN: begin
            if (row == last_row) begin
              state_next = ST_FLUSH;
            end else begin
              row_next = row + RowW'(1);
            end
          end
          ST_FLUSH: begin
            state_next = ST_RUN;
            row_next   = '0;
          end
          default: state_next = ST_RUN;
        endcase
      end else begin
        col_next = col + ColW'(1);
      end
    end
  end

  // line chain, one cell per column, entry point set by the grid width
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_line
    line_pair_t nxt;
    if (j == MAX_COLS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = chain[j+1];
    end
    gnmc_cell u_cell (
      .clk       (clk),
      .shift     (step),
      .entry     (last_col == ColW'(j)),
      .push_bits (push),
      .next_bits (nxt),
      .bits      (chain[j])
    );
  end

  assign head       = chain[0];
  assign push       = {head[0], mark_in};
  assign center_row = flushing ? row : row - RowW'(1);
  assign has_prev   = flushing || (row != '0);
  assign col_vec    = {head[1] && (center_row != '0), head[0], mark_in};

  always_comb begin
    meta.emit_a     = has_prev && (col != '0);
    meta.emit_b     = has_prev && (col == last_col);
    meta.frame_last = flushing;
    meta.first_col  = col == '0;
    meta.row        = OUT_ROW_W'(center_row);
    meta.col        = OUT_COL_W'(col);
  end

  gnmc_window u_window (
    .clk     (clk),
    .rst     (rst),
    .load    (step),
    .col_vec (col_vec),
    .meta_in (meta),
    .room    (q_room),
    .ready   (win_ready),
    .wr      (wr)
  );

  gnmc_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .pop   (m_tvalid && m_tready),
    .valid (m_tvalid),
    .room  (q_room),
    .head  (q_head)
  );

  assign m_tdata = {(TDATA_W - OUT_COL_W - OUT_ROW_W - CNT_W)'(0),
                    q_head.out_col, q_head.out_row, q_head.neighbour_count};
  assign m_tlast = q_head.frame_end;

endmodule

// File: rtl/gnmc_checker.sv
// port-level checks of the grid mark counter, bound to the top level
`include "assert_macros.svh"

module gnmc_checker import gnmc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast
);

  logic [TDATA_W:0] out_word;
  logic [CNT_W-1:0] cnt;

  assign out_word = {m_tlast, m_tdata};
  assign cnt      = m_tdata[CNT_W-1:0];

  // queue is empty right after reset
  `GNMC_ASSERT_RST(a_rst_empty, rst, !m_tvalid, "output word present after reset")

  // stalled word holds
  `GNMC_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word), "stall broken")

  // the corner cell window holds at most four cells
  `GNMC_ASSERT_IMP(a_corner, m_tvalid && m_tlast, cnt <= CNT_W'(4), "corner count above four")

  // counts never exceed a full window
  `GNMC_ASSERT_IMP(a_count_max, m_tvalid, cnt <= CNT_W'(9), "count above nine")

endmodule

bind grid_neighbour_mark_counter gnmc_checker u_gnmc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
